// ===== rtl/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg: touch calibrate and release shared definitions
// field widths, register indexes, rotation and event codes, divide constants
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

  localparam int RAW_W   = 10;
  localparam int PRES_W  = 16;
  localparam int TIME_W  = 32;
  localparam int COEF_W  = 32;
  localparam int DELAY_W = 16;
  localparam int COORD_W = 16;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int TCR_MIN_PRESSURE = 10;
  localparam int TCR_MAX_PRESSURE = 1000;

  // calibration scale and rounding half
  localparam int CAL_SCALE = 10000;
  localparam int CAL_HALF  = 5000;

  // product of coefficient and raw reading, and the full affine sum
  localparam int PROD_W = COEF_W + RAW_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // magnitude clamp: any quotient beyond this saturates in every rotation
  localparam int MAG_W = 29;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // floor(m / 10000) == (m * RECIP) >> RECIP_SHIFT for all m below 2^29
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 43;
  localparam logic [RECIP_W-1:0] RECIP = 30'd879609303;
  localparam int RPROD_W = MAG_W + RECIP_W;
  localparam int QUO_W   = RPROD_W - RECIP_SHIFT;

  // width of calibrated and rotated values before saturation
  localparam int VAL_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_C,
    REG_COEF_D,
    REG_COEF_E,
    REG_COEF_F,
    REG_ROTATION,
    REG_RELEASE_DELAY
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } rot_t;

  typedef enum logic {
    EV_MOVE,
    EV_RELEASE
  } event_kind_t;

endpackage

`default_nettype wire

// ===== rtl/touch_calibrate_and_release_core.sv =====
// ----------------------------------------------------------------------------
// touch_calibrate_and_release_core: touch sample calibration and release
// affine calibration, rotation and saturation of touch samples, with a
// release event once valid pressure has been absent for the release delay
// ----------------------------------------------------------------------------
// results leave in the order their samples were accepted
// throughput: one sample per cycle while the output accepts; a sample that causes no event emits nothing
// five-stage pipeline: input register, products, affine sum and clamp,
// reciprocal multiply, rotation and saturation into the output register
// reset: synchronous; clears pipeline valids and touch state, loads default
// calibration (identity), rotation none and a release delay of 75 ms
`default_nettype none

module touch_calibrate_and_release_core
  import tcr_pkg::*;
#(
  parameter int MIN_PRESSURE = TCR_MIN_PRESSURE,
  parameter int MAX_PRESSURE = TCR_MAX_PRESSURE
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  // raw_x[9:0], raw_y[19:10], pressure[35:20], now_ms[67:36], zero pad
  input  wire  [IN_DATA_W-1:0]    s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  // screen_x[15:0], screen_y[31:16]
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  // event_kind[0]
  output logic [0:0]              m_axis_tuser,
  input  wire                     cfg_we,
  input  wire  [CFG_IDX_W-1:0]    cfg_index,
  input  wire  [CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [PRES_W-1:0] MIN_P = PRES_W'(MIN_PRESSURE);
  localparam logic [PRES_W-1:0] MAX_P = PRES_W'(MAX_PRESSURE);

  // configuration
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d, coef_e, coef_f;
  rot_t                     rotation;
  logic [DELAY_W-1:0]       release_delay_ms;

  // touch state
  logic              touching;
  logic [TIME_W-1:0] last_touch_ms;

  // input fields
  logic [RAW_W-1:0]  raw_x, raw_y;
  logic [PRES_W-1:0] pressure;
  logic [TIME_W-1:0] now_ms;
  logic              in_acc, press_ok, rel_hit;
  logic [TIME_W-1:0] elapsed;

  // pipeline
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  event_kind_t k1, k2, k3, k4, k5;
  logic [RAW_W-1:0] s1_x, s1_y;
  logic signed [PROD_W-1:0] s2_pa, s2_pb, s2_pd, s2_pe;
  logic signed [SUM_W-1:0]  sum_u, sum_v;
  logic [MAG_W-1:0]         s3_mu, s3_mv;
  logic                     s3_nu, s3_nv;
  logic [RPROD_W-1:0]       s4_pu, s4_pv;
  logic                     s4_nu, s4_nv;
  logic [QUO_W-1:0]         q_u, q_v;
  logic signed [VAL_W-1:0]  val_u, val_v, rot_x, rot_y;
  logic [COORD_W-1:0]       screen_x, screen_y;

  function automatic logic [MAG_W-1:0] mag_clamp(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] m;
    m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    if (m > SUM_W'(MAG_MAX)) begin
      return MAG_MAX;
    end
    return m[MAG_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] apply_sign(input logic [QUO_W-1:0] q,
                                                         input logic neg);
    logic signed [VAL_W-1:0] w;
    w = $signed(VAL_W'(q));
    return neg ? -w : w;
  endfunction

  function automatic logic [COORD_W-1:0] sat16(input logic signed [VAL_W-1:0] v);
    if (v > $signed(VAL_W'(32767))) begin
      return 16'h7fff;
    end
    if (v < -$signed(VAL_W'(32768))) begin
      return 16'h8000;
    end
    return v[COORD_W-1:0];
  endfunction

  assign raw_x    = s_axis_tdata[9:0];
  assign raw_y    = s_axis_tdata[19:10];
  assign pressure = s_axis_tdata[35:20];
  assign now_ms   = s_axis_tdata[67:36];

  assign rdy5 = !v5 || m_axis_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_axis_tready = rdy1;
  assign in_acc        = s_axis_tvalid && rdy1;

  assign press_ok = (pressure > MIN_P) && (pressure < MAX_P);
  assign elapsed  = now_ms - last_touch_ms;
  assign rel_hit  = !press_ok && touching && (elapsed >= TIME_W'(release_delay_ms));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a           <= COEF_W'(CAL_SCALE);
      coef_b           <= '0;
      coef_c           <= '0;
      coef_d           <= '0;
      coef_e           <= COEF_W'(CAL_SCALE);
      coef_f           <= '0;
      rotation         <= ROT_0;
      release_delay_ms <= DELAY_W'(75);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_A:        coef_a <= $signed(cfg_data);
        REG_COEF_B:        coef_b <= $signed(cfg_data);
        REG_COEF_C:        coef_c <= $signed(cfg_data);
        REG_COEF_D:        coef_d <= $signed(cfg_data);
        REG_COEF_E:        coef_e <= $signed(cfg_data);
        REG_COEF_F:        coef_f <= $signed(cfg_data);
        REG_ROTATION:      rotation <= rot_t'(cfg_data[1:0]);
        REG_RELEASE_DELAY: release_delay_ms <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // touch state
  always_ff @(posedge clk) begin
    if (rst) begin
      touching      <= 1'b0;
      last_touch_ms <= '0;
    end else if (in_acc) begin
      if (press_ok) begin
        touching      <= 1'b1;
        last_touch_ms <= now_ms;
      end else if (rel_hit) begin
        touching <= 1'b0;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_acc && (press_ok || rel_hit);
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      k1   <= press_ok ? EV_MOVE : EV_RELEASE;
      s1_x <= raw_x;
      s1_y <= raw_y;
    end
  end

  // stage 2: coefficient products
  always_ff @(posedge clk) begin
    if (rdy2) begin
      k2    <= k1;
      s2_pa <= coef_a * $signed({1'b0, s1_x});
      s2_pb <= coef_b * $signed({1'b0, s1_y});
      s2_pd <= coef_d * $signed({1'b0, s1_x});
      s2_pe <= coef_e * $signed({1'b0, s1_y});
    end
  end

  // stage 3: affine sum with rounding, sign and clamped magnitude
  assign sum_u = SUM_W'(s2_pa) + SUM_W'(s2_pb) + SUM_W'(coef_c) + SUM_W'(CAL_HALF);
  assign sum_v = SUM_W'(s2_pd) + SUM_W'(s2_pe) + SUM_W'(coef_f) + SUM_W'(CAL_HALF);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      k3    <= k2;
      s3_nu <= sum_u[SUM_W-1];
      s3_nv <= sum_v[SUM_W-1];
      s3_mu <= mag_clamp(sum_u);
      s3_mv <= mag_clamp(sum_v);
    end
  end

  // stage 4: divide by the scale through a reciprocal product
  always_ff @(posedge clk) begin
    if (rdy4) begin
      k4    <= k3;
      s4_nu <= s3_nu;
      s4_nv <= s3_nv;
      s4_pu <= RPROD_W'(s3_mu) * RPROD_W'(RECIP);
      s4_pv <= RPROD_W'(s3_mv) * RPROD_W'(RECIP);
    end
  end

  // stage 5: truncation toward zero, rotation, saturation
  assign q_u   = s4_pu[RPROD_W-1:RECIP_SHIFT];
  assign q_v   = s4_pv[RPROD_W-1:RECIP_SHIFT];
  assign val_u = apply_sign(q_u, s4_nu);
  assign val_v = apply_sign(q_v, s4_nv);

  always_comb begin
    case (rotation)
      ROT_90: begin
        rot_x = $signed(VAL_W'(CAL_SCALE)) - val_v;
        rot_y = val_u;
      end
      ROT_180: begin
        rot_x = $signed(VAL_W'(CAL_SCALE)) - val_u;
        rot_y = $signed(VAL_W'(CAL_SCALE)) - val_v;
      end
      ROT_270: begin
        rot_x = val_v;
        rot_y = $signed(VAL_W'(CAL_SCALE)) - val_u;
      end
      default: begin
        rot_x = val_u;
        rot_y = val_v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      k5       <= k4;
      screen_x <= (k4 == EV_RELEASE) ? '0 : sat16(rot_x);
      screen_y <= (k4 == EV_RELEASE) ? '0 : sat16(rot_y);
    end
  end

  assign m_axis_tvalid   = v5;
  assign m_axis_tdata    = {screen_y, screen_x};
  assign m_axis_tuser[0] = k5;

  // a release carries zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[0] == EV_RELEASE)) |-> (m_axis_tdata == '0))
    else $error("release result with non-zero coordinates");

  // a sample in the pressure window starts a touch at its timestamp
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && press_ok) |=> (touching && (last_touch_ms == $past(now_ms))))
    else $error("touch state not taken from valid sample");

  // a release ends the touch
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && rel_hit) |=> !touching)
    else $error("touch still active after release");

  // input only stalls behind a full pipeline and a held result
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && v1 && v2 && v3 && v4))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: touch calibrate and release core testbench
// drives touch samples into the stream input under random gaps and back
// pressure, predicts each move and release event from a local model of the
// affine calibration, rotation, saturation and release timer, and compares
// every event on the output stream against the oldest pending prediction
// ----------------------------------------------------------------------------
module tb;
  import tcr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 235;

  typedef struct {
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [PRES_W-1:0] pressure;
    logic [TIME_W-1:0] now_ms;
  } touch_sample_t;

  typedef struct {
    event_kind_t               kind;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
  } touch_event_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // calibration shadow and touch state of the predictor
  longint                cal_a, cal_b, cal_c, cal_d, cal_e, cal_f;
  rot_t                  cal_rot;
  logic [DELAY_W-1:0]    cal_delay;
  bit                    pen_down;
  logic [TIME_W-1:0]     pen_last_ms;

  touch_event_t          pending_events[$];
  int                    error_count = 0;
  int                    cycle_count = 0;
  bit                    tx_idle = 1'b1;
  bit                    rx_idle = 1'b1;
  int                    rx_hold = 0;
  logic [TIME_W-1:0]     stamp_ms;

  touch_calibrate_and_release_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  task automatic predict_touch_event(touch_sample_t s);
    longint       x, y, u, v, sx, sy;
    logic [31:0]  elapsed;
    touch_event_t ev;
    x = s.raw_x;
    y = s.raw_y;
    if (s.pressure > TCR_MIN_PRESSURE && s.pressure < TCR_MAX_PRESSURE) begin
      u = (cal_a * x + cal_b * y + cal_c + CAL_HALF) / CAL_SCALE;
      v = (cal_d * x + cal_e * y + cal_f + CAL_HALF) / CAL_SCALE;
      case (cal_rot)
        ROT_90: begin
          sx = CAL_SCALE - v;
          sy = u;
        end
        ROT_180: begin
          sx = CAL_SCALE - u;
          sy = CAL_SCALE - v;
        end
        ROT_270: begin
          sx = v;
          sy = CAL_SCALE - u;
        end
        default: begin
          sx = u;
          sy = v;
        end
      endcase
      pen_down    = 1'b1;
      pen_last_ms = s.now_ms;
      ev.kind     = EV_MOVE;
      ev.screen_x = clamp_coord(sx);
      ev.screen_y = clamp_coord(sy);
      pending_events.push_back(ev);
    end else begin
      elapsed = s.now_ms - pen_last_ms;
      if (pen_down && elapsed >= {16'd0, cal_delay}) begin
        pen_down    = 1'b0;
        ev.kind     = EV_RELEASE;
        ev.screen_x = '0;
        ev.screen_y = '0;
        pending_events.push_back(ev);
      end
    end
  endtask

  always @(posedge clk) begin : event_checker
    touch_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $error("event with nothing pending: event_kind %0d screen_x %0d screen_y %0d",
               m_axis_tuser[0], $signed(m_axis_tdata[15:0]),
               $signed(m_axis_tdata[31:16]));
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser[0] !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tdata[15:0] !== want.screen_x) begin
          $error("screen_x: expected %0d, got %0d", want.screen_x,
                 $signed(m_axis_tdata[15:0]));
          error_count++;
        end
        if (m_axis_tdata[31:16] !== want.screen_y) begin
          $error("screen_y: expected %0d, got %0d", want.screen_y,
                 $signed(m_axis_tdata[31:16]));
          error_count++;
        end
      end
    end
  end

  // result side: random stall per event when rx_idle is set, plus long hold-offs on demand
  initial begin : event_sink
    int wait_cycles;
    m_axis_tready = 1'b1;
    forever begin
      if (rx_hold > 0) begin
        repeat (rx_hold) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
        end
        rx_hold = 0;
      end
      wait_cycles = rx_idle ? $urandom_range(0, 13) : 0;
      repeat (wait_cycles) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  function automatic touch_sample_t make_sample(int x, int y, int p, logic [31:0] now);
    touch_sample_t s;
    s.raw_x    = x[RAW_W-1:0];
    s.raw_y    = y[RAW_W-1:0];
    s.pressure = p[PRES_W-1:0];
    s.now_ms   = now;
    return s;
  endfunction

  task automatic send_sample(touch_sample_t s);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, s.now_ms, s.pressure, s.raw_y, s.raw_x};
    // hold the request until the core takes it
    do @(posedge clk); while (!s_axis_tready);
    predict_touch_event(s);
  endtask

  task automatic wait_for_events();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    wait_for_events();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_COEF_A:   cal_a = longint'($signed(val));
      REG_COEF_B:   cal_b = longint'($signed(val));
      REG_COEF_C:   cal_c = longint'($signed(val));
      REG_COEF_D:   cal_d = longint'($signed(val));
      REG_COEF_E:   cal_e = longint'($signed(val));
      REG_COEF_F:   cal_f = longint'($signed(val));
      REG_ROTATION: cal_rot = rot_t'(val[1:0]);
      default:      cal_delay = val[DELAY_W-1:0];
    endcase
  endtask

  task automatic write_calibration(int a, int b, int c, int d, int e, int f,
                                   rot_t rot, int delay);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
    write_reg(REG_COEF_E, e);
    write_reg(REG_COEF_F, f);
    write_reg(REG_ROTATION, rot);
    write_reg(REG_RELEASE_DELAY, delay);
  endtask

  function automatic int extreme_coef();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 0;
      3:       return CAL_SCALE;
      4:       return -CAL_SCALE;
      default: return $urandom;
    endcase
  endfunction

  function automatic int plausible_gain();
    int g;
    g = $urandom_range(5000, 40000);
    return $urandom_range(0, 1) ? g : -g;
  endfunction

  function automatic int valid_pressure();
    return $urandom_range(TCR_MIN_PRESSURE + 1, TCR_MAX_PRESSURE - 1);
  endfunction

  function automatic int invalid_pressure();
    if ($urandom_range(0, 1)) return $urandom_range(0, TCR_MIN_PRESSURE);
    return $urandom_range(TCR_MAX_PRESSURE, 65535);
  endfunction

  // reset calibration is identity, rotation none, 75 ms release delay
  task automatic test_default_calibration();
    send_sample(make_sample(0, 0, 500, 100));
    send_sample(make_sample(1023, 1023, 500, 110));
  endtask

  task automatic test_pressure_window();
    send_sample(make_sample(300, 400, 0, 200));
    send_sample(make_sample(300, 400, TCR_MIN_PRESSURE, 210));
    send_sample(make_sample(512, 256, TCR_MIN_PRESSURE + 1, 220));
    send_sample(make_sample(1, 1022, TCR_MAX_PRESSURE - 1, 230));
    send_sample(make_sample(300, 400, TCR_MAX_PRESSURE, 240));
    send_sample(make_sample(300, 400, 65535, 400));
  endtask

  task automatic test_release_timing();
    // elapsed time taken across the timestamp wrap
    send_sample(make_sample(600, 700, 500, 32'hffff_fff0));
    send_sample(make_sample(0, 0, 0, 32'h0000_0030));
    send_sample(make_sample(0, 0, 0, 32'h0000_003b));
    send_sample(make_sample(0, 0, 0, 32'h0000_0100));
    send_sample(make_sample(600, 700, 500, 1000));
    send_sample(make_sample(0, 0, 5, 1074));
  endtask

  task automatic test_register_extremes();
    rot_t r;
    drain_pipeline();
    for (int i = 0; i < 4; i++) begin
      r = rot_t'(i);
      write_reg(REG_ROTATION, r);
      send_sample(make_sample(100, 900, 500, 2000 + i));
      drain_pipeline();
    end
    write_calibration(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ROT_0, 75);
    send_sample(make_sample(1023, 1023, 500, 3000));
    send_sample(make_sample(0, 0, 500, 3001));
    drain_pipeline();
    // rounding of negative sums truncates toward zero
    write_calibration(0, 0, -14999, 0, 0, -25001, ROT_0, 75);
    send_sample(make_sample(513, 7, 500, 3100));
    drain_pipeline();
    write_reg(REG_RELEASE_DELAY, 0);
    send_sample(make_sample(1, 2, 500, 4000));
    send_sample(make_sample(1, 2, 0, 4000));
    drain_pipeline();
    write_reg(REG_RELEASE_DELAY, 65535);
    send_sample(make_sample(3, 4, 500, 5000));
    send_sample(make_sample(3, 4, 0, 5000 + 65534));
    send_sample(make_sample(3, 4, 0, 5000 + 65535));
    drain_pipeline();
  endtask

  // receiver holds off while a burst fills the pipeline and stalls the input
  task automatic test_backpressure();
    drain_pipeline();
    write_calibration(plausible_gain(), 1500, 2000000, -700, plausible_gain(),
                      -4000000, ROT_90, 40);
    tx_idle = 1'b0;
    rx_hold = 300;
    for (int i = 0; i < 60; i++) begin
      stamp_ms += 3;
      send_sample(make_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                              valid_pressure(), stamp_ms));
    end
    drain_pipeline();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_strokes();
    int sent;
    int strokes;
    int lifts;
    bit paused;
    touch_sample_t s;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      case (phase % 4)
        0, 3: write_calibration(plausible_gain(), $urandom_range(0, 4000) - 2000,
                                $urandom_range(0, 60000000) - 30000000,
                                $urandom_range(0, 4000) - 2000, plausible_gain(),
                                $urandom_range(0, 60000000) - 30000000,
                                rot_t'((phase + phase / 4) % 4),
                                $urandom_range(1, 300));
        1:    write_calibration($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, rot_t'((phase + phase / 4) % 4),
                                $urandom_range(1, 300));
        default: write_calibration(extreme_coef(), extreme_coef(), extreme_coef(),
                                   extreme_coef(), extreme_coef(), extreme_coef(),
                                   rot_t'((phase + phase / 4) % 4),
                                   (phase == 2) ? 0 : 65535);
      endcase
      tx_idle = (phase % 3) != 1;
      rx_idle = (phase % 4) != 2;
      sent    = 0;
      paused  = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if (!paused && sent > PHASE_ITEMS / 2) begin
          wait_for_events();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          strokes = $urandom_range(1, 12);
          for (int k = 0; k < strokes; k++) begin
            stamp_ms += $urandom_range(1, 20);
            send_sample(make_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                                    valid_pressure(), stamp_ms));
            sent++;
          end
          lifts = $urandom_range(1, 6);
          for (int k = 0; k < lifts; k++) begin
            stamp_ms += $urandom_range(0, cal_delay / 3 + 10);
            send_sample(make_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                                    invalid_pressure(), stamp_ms));
            sent++;
          end
        end else begin
          s = make_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 65535), $urandom);
          stamp_ms = s.now_ms;
          send_sample(s);
          sent++;
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_COEF_A;
    cfg_data      = '0;
    cal_a         = CAL_SCALE;
    cal_b         = 0;
    cal_c         = 0;
    cal_d         = 0;
    cal_e         = CAL_SCALE;
    cal_f         = 0;
    cal_rot       = ROT_0;
    cal_delay     = 75;
    pen_down      = 1'b0;
    pen_last_ms   = '0;
    stamp_ms      = $urandom;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_calibration();
    test_pressure_window();
    test_release_timing();
    test_register_extremes();
    test_backpressure();
    test_random_strokes();

    drain_pipeline();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
